// ===== rtl/cbse_pkg.sv =====
package cbse_pkg;

    // Field widths
    localparam int IDX_W   = 4;
    localparam int COORD_W = 24;
    localparam int T_W     = 17;

    // Weight datapath
    localparam int SQ_W        = 33;   // t^2 <= 2^32
    localparam int CU_W        = 49;   // t^3 <= 2^48
    localparam int POLY_W      = 52;   // basis numerators, scaled by 6 * 2^48
    localparam int Q_SHIFT     = 17;
    localparam int Q_W         = 34;   // (W + 3*2^16) >> 17
    localparam int QLO_W       = 17;
    localparam int QHI_W       = Q_W - QLO_W;
    localparam int RECIP_W     = 34;
    localparam int RECIP_SHIFT = 35;
    localparam int PP_W        = 51;
    localparam int FULL_W      = PP_W + QLO_W;
    localparam int W_W         = 32;   // Q32 basis weight

    // Blend datapath
    localparam int PROD_W     = W_W + 1 + COORD_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int ACC_W      = PAIR_W + 1;
    localparam int FRAC_SHIFT = 32;
    localparam int RES_W      = ACC_W - FRAC_SHIFT;

    localparam int NUM_TAPS = 4;
    localparam int NUM_AXES = 2;

    // Pipeline stage numbers
    localparam int ST_IN      = 1;
    localparam int ST_SQ      = 2;
    localparam int ST_CU      = 3;
    localparam int ST_Q       = 4;
    localparam int ST_PP      = 5;
    localparam int ST_MEM     = 6;
    localparam int ST_MUL     = 7;
    localparam int ST_PAIR    = 8;
    localparam int ST_SUM     = 9;
    localparam int ST_OUT     = 10;
    localparam int NUM_STAGES = 10;

    localparam logic [T_W-1:0]          T_ONE     = 17'h1_0000;
    localparam logic [RECIP_W-1:0]      RECIP3    = 34'h2_AAAA_AAAB;  // ceil(2^35 / 3)
    localparam logic [POLY_W-1:0]       W_ONE     = 52'h1_0000_0000_0000;
    localparam logic [POLY_W-1:0]       W_FOUR    = 52'h4_0000_0000_0000;
    localparam logic [POLY_W-1:0]       Q_BIAS    = 52'h3_0000;
    localparam logic signed [ACC_W-1:0] HALF_LSB  = 59'sh8000_0000;
    localparam logic signed [RES_W-1:0] RES_MAX   = 27'sd8388607;
    localparam logic signed [RES_W-1:0] RES_MIN   = -27'sd8388608;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [T_W-1:0]            tparam_t;
    typedef logic [W_W-1:0]            weight_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef logic [NUM_STAGES:1] stage_vec_t;

endpackage

// ===== rtl/cbse_weight_gen.sv =====
module cbse_weight_gen (
    input  logic                 clk,
    input  cbse_pkg::stage_vec_t stage_en,
    input  cbse_pkg::tparam_t    t_in,
    output cbse_pkg::weight_t    weight [cbse_pkg::NUM_TAPS]
);

    // stage 2: squares
    logic [cbse_pkg::T_W-1:0]    u_s1;
    logic [2*cbse_pkg::T_W-1:0]  t_sq;
    logic [2*cbse_pkg::T_W-1:0]  u_sq;
    logic [cbse_pkg::T_W-1:0]    t_s2_reg;
    logic [cbse_pkg::T_W-1:0]    u_s2_reg;
    logic [cbse_pkg::SQ_W-1:0]   t2_s2_reg;
    logic [cbse_pkg::SQ_W-1:0]   u2_s2_reg;

    // stage 3: cubes
    logic [cbse_pkg::SQ_W+cbse_pkg::T_W-1:0] t_cu;
    logic [cbse_pkg::SQ_W+cbse_pkg::T_W-1:0] u_cu;
    logic [cbse_pkg::T_W-1:0]    t_s3_reg;
    logic [cbse_pkg::SQ_W-1:0]   t2_s3_reg;
    logic [cbse_pkg::CU_W-1:0]   t3_s3_reg;
    logic [cbse_pkg::CU_W-1:0]   u3_s3_reg;

    // stage 4: basis numerators, pre-scaled
    logic [cbse_pkg::POLY_W-1:0] te;
    logic [cbse_pkg::POLY_W-1:0] t2e;
    logic [cbse_pkg::POLY_W-1:0] t3e;
    logic [cbse_pkg::POLY_W-1:0] tx3;
    logic [cbse_pkg::POLY_W-1:0] t2x3;
    logic [cbse_pkg::POLY_W-1:0] t3x3;
    logic [cbse_pkg::POLY_W-1:0] w_poly [cbse_pkg::NUM_TAPS];
    logic [cbse_pkg::Q_W-1:0]    q_reg  [cbse_pkg::NUM_TAPS];

    // stage 5/6: divide by 3 through the reciprocal
    logic [cbse_pkg::PP_W-1:0]   pp_hi_reg [cbse_pkg::NUM_TAPS];
    logic [cbse_pkg::PP_W-1:0]   pp_lo_reg [cbse_pkg::NUM_TAPS];
    logic [cbse_pkg::FULL_W-1:0] full      [cbse_pkg::NUM_TAPS];
    cbse_pkg::weight_t           weight_reg [cbse_pkg::NUM_TAPS];

    function automatic logic [cbse_pkg::Q_W-1:0] scale_q(input logic [cbse_pkg::POLY_W-1:0] w);
        logic [cbse_pkg::POLY_W-1:0] s;
        s = w + cbse_pkg::Q_BIAS;
        return s[cbse_pkg::Q_W+cbse_pkg::Q_SHIFT-1:cbse_pkg::Q_SHIFT];
    endfunction

    assign u_s1 = cbse_pkg::T_ONE - t_in;
    assign t_sq = t_in * t_in;
    assign u_sq = u_s1 * u_s1;

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_SQ])
        begin
            t_s2_reg  <= t_in;
            u_s2_reg  <= u_s1;
            t2_s2_reg <= t_sq[cbse_pkg::SQ_W-1:0];
            u2_s2_reg <= u_sq[cbse_pkg::SQ_W-1:0];
        end
    end

    assign t_cu = t2_s2_reg * t_s2_reg;
    assign u_cu = u2_s2_reg * u_s2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_CU])
        begin
            t3_s3_reg <= t_cu[cbse_pkg::CU_W-1:0];
            u3_s3_reg <= u_cu[cbse_pkg::CU_W-1:0];
            t2_s3_reg <= t2_s2_reg;
            t_s3_reg  <= t_s2_reg;
        end
    end

    always_comb
    begin
        te   = cbse_pkg::POLY_W'(t_s3_reg);
        t2e  = cbse_pkg::POLY_W'(t2_s3_reg);
        t3e  = cbse_pkg::POLY_W'(t3_s3_reg);
        tx3  = (te << 1) + te;
        t2x3 = (t2e << 1) + t2e;
        t3x3 = (t3e << 1) + t3e;
        w_poly[0] = cbse_pkg::POLY_W'(u3_s3_reg);
        w_poly[1] = cbse_pkg::W_FOUR + t3x3 - (t2x3 << 17);
        w_poly[2] = cbse_pkg::W_ONE + (tx3 << 32) + (t2x3 << 16) - t3x3;
        w_poly[3] = t3e;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_Q])
        begin
            for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
            begin
                q_reg[j] <= scale_q(w_poly[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_PP])
        begin
            for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
            begin
                pp_hi_reg[j] <= q_reg[j][cbse_pkg::Q_W-1:cbse_pkg::QLO_W] * cbse_pkg::RECIP3;
                pp_lo_reg[j] <= q_reg[j][cbse_pkg::QLO_W-1:0] * cbse_pkg::RECIP3;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
        begin
            full[j] = {pp_hi_reg[j], {cbse_pkg::QLO_W{1'b0}}}
                    + cbse_pkg::FULL_W'(pp_lo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_MEM])
        begin
            for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
            begin
                weight_reg[j] <= full[j][cbse_pkg::RECIP_SHIFT+cbse_pkg::W_W-1:cbse_pkg::RECIP_SHIFT];
            end
        end
    end

    assign weight = weight_reg;

endmodule

// ===== rtl/cbse_point_store.sv =====
module cbse_point_store #(
    parameter int NUM_POINTS = 10,
    parameter int ADDR_W     = 4
) (
    input  logic                 clk,
    input  cbse_pkg::stage_vec_t stage_en,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  cbse_pkg::point_t     wr_point,
    input  logic [ADDR_W-1:0]    rd_base,
    output cbse_pkg::point_t     rd_point [cbse_pkg::NUM_TAPS]
);

    localparam logic [ADDR_W:0] NP = (ADDR_W+1)'(NUM_POINTS);

    logic [ADDR_W-1:0] rd_addr [cbse_pkg::NUM_TAPS];

    // base + j wraps around the ring; base < NUM_POINTS so one subtract is enough
    always_comb
    begin
        logic [ADDR_W:0] sum;
        for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
        begin
            sum = {1'b0, rd_base} + (ADDR_W+1)'(j);
            if (sum >= NP)
            begin
                sum = sum - NP;
            end
            rd_addr[j] = sum[ADDR_W-1:0];
        end
    end

    // one copy of the table per tap, each with a single read port
    for (genvar j = 0; j < cbse_pkg::NUM_TAPS; j++)
    begin : g_copy
        cbse_pkg::point_t mem [NUM_POINTS];
        cbse_pkg::point_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (stage_en[cbse_pkg::ST_MEM] && wr_en)
            begin
                mem[wr_addr] <= wr_point;
            end
            if (stage_en[cbse_pkg::ST_MEM])
            begin
                rd_reg <= mem[rd_addr[j]];
            end
        end

        assign rd_point[j] = rd_reg;
    end

endmodule

// ===== rtl/cbse_blend.sv =====
module cbse_blend (
    input  logic                 clk,
    input  cbse_pkg::stage_vec_t stage_en,
    input  cbse_pkg::weight_t    weight [cbse_pkg::NUM_TAPS],
    input  cbse_pkg::point_t     point  [cbse_pkg::NUM_TAPS],
    output cbse_pkg::coord_t     curve_x,
    output cbse_pkg::coord_t     curve_y
);

    cbse_pkg::coord_t              coord_sel [cbse_pkg::NUM_AXES][cbse_pkg::NUM_TAPS];
    logic signed [cbse_pkg::PROD_W-1:0] prod_reg [cbse_pkg::NUM_AXES][cbse_pkg::NUM_TAPS];
    logic signed [cbse_pkg::PAIR_W-1:0] pair_reg [cbse_pkg::NUM_AXES][2];
    logic signed [cbse_pkg::ACC_W-1:0]  acc_reg  [cbse_pkg::NUM_AXES];
    logic signed [cbse_pkg::RES_W-1:0]  res      [cbse_pkg::NUM_AXES];
    cbse_pkg::coord_t              curve_next [cbse_pkg::NUM_AXES];
    cbse_pkg::coord_t              curve_reg  [cbse_pkg::NUM_AXES];

    always_comb
    begin
        for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
        begin
            coord_sel[0][j] = point[j].x;
            coord_sel[1][j] = point[j].y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_MUL])
        begin
            for (int a = 0; a < cbse_pkg::NUM_AXES; a++)
            begin
                for (int j = 0; j < cbse_pkg::NUM_TAPS; j++)
                begin
                    prod_reg[a][j] <= $signed({1'b0, weight[j]}) * coord_sel[a][j];
                end
            end
        end
        if (stage_en[cbse_pkg::ST_PAIR])
        begin
            for (int a = 0; a < cbse_pkg::NUM_AXES; a++)
            begin
                pair_reg[a][0] <= cbse_pkg::PAIR_W'(prod_reg[a][0])
                                + cbse_pkg::PAIR_W'(prod_reg[a][1]);
                pair_reg[a][1] <= cbse_pkg::PAIR_W'(prod_reg[a][2])
                                + cbse_pkg::PAIR_W'(prod_reg[a][3]);
            end
        end
        if (stage_en[cbse_pkg::ST_SUM])
        begin
            for (int a = 0; a < cbse_pkg::NUM_AXES; a++)
            begin
                // round half up folded into the final add
                acc_reg[a] <= cbse_pkg::ACC_W'(pair_reg[a][0])
                            + cbse_pkg::ACC_W'(pair_reg[a][1])
                            + cbse_pkg::HALF_LSB;
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < cbse_pkg::NUM_AXES; a++)
        begin
            res[a] = acc_reg[a][cbse_pkg::ACC_W-1:cbse_pkg::FRAC_SHIFT];
            if (res[a] > cbse_pkg::RES_MAX)
            begin
                curve_next[a] = cbse_pkg::RES_MAX[cbse_pkg::COORD_W-1:0];
            end
            else if (res[a] < cbse_pkg::RES_MIN)
            begin
                curve_next[a] = cbse_pkg::RES_MIN[cbse_pkg::COORD_W-1:0];
            end
            else
            begin
                curve_next[a] = res[a][cbse_pkg::COORD_W-1:0];
            end
        end
    end

    // output register shares the last valid bit with the top level
    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_OUT])
        begin
            for (int a = 0; a < cbse_pkg::NUM_AXES; a++)
            begin
                curve_reg[a] <= curve_next[a];
            end
        end
    end

    assign curve_x = curve_reg[0];
    assign curve_y = curve_reg[1];

endmodule

// ===== rtl/closed_cubic_bspline_evaluator_unit.sv =====
// Closed uniform cubic B-spline evaluator. A load transaction (operation 0) writes control
// point (coord_x, coord_y) into slot point_index of a ring of NUM_POINTS points; slots at or
// above NUM_POINTS are ignored and a load returns no result. An evaluate transaction
// (operation 1) takes segment point_index (taken modulo NUM_POINTS) and param_t in Q16
// (values above 1.0 clamp to 1.0), blends points s..s+3 around the ring with the cubic
// basis rounded to Q32 and returns one saturated (curve_x, curve_y). Every point an evaluate
// touches must have been loaded since reset; unloaded slots read as garbage. One
// transaction is accepted per clock; an evaluate reaches result_valid through a 10-stage
// pipeline (input register, square, cube, basis polynomials, a two-stage
// multiply by 1/3 alongside the point-table read, the coordinate multipliers, a two-level
// adder tree with rounding, and saturation into the output register). The point table is
// kept as four copies so all four taps are read in the same cycle. Backpressure from
// result_ready only holds stages that carry an item, so empty stages keep filling while a
// finished result waits; the input stalls only once all ten stages hold an item.
module closed_cubic_bspline_evaluator_unit #(
    parameter int NUM_POINTS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               operation,
    input  logic [cbse_pkg::IDX_W-1:0]         point_index,
    input  logic signed [cbse_pkg::COORD_W-1:0] coord_x,
    input  logic signed [cbse_pkg::COORD_W-1:0] coord_y,
    input  logic [cbse_pkg::T_W-1:0]           param_t,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [cbse_pkg::COORD_W-1:0] curve_x,
    output logic signed [cbse_pkg::COORD_W-1:0] curve_y
);

    localparam int ADDR_W    = $clog2(NUM_POINTS);
    localparam int SEL_W     = (ADDR_W > cbse_pkg::IDX_W) ? ADDR_W : cbse_pkg::IDX_W;
    localparam logic [SEL_W:0] NP_SEL = (SEL_W+1)'(NUM_POINTS);
    localparam int MOD_STEPS = ((1 << cbse_pkg::IDX_W) - 1) / NUM_POINTS;

    cbse_pkg::stage_vec_t stage_en;
    cbse_pkg::stage_vec_t valid_reg;
    cbse_pkg::stage_vec_t valid_next;

    logic [SEL_W:0]          idx_ext;
    logic [SEL_W:0]          seg_mod;
    cbse_pkg::op_t           op_next;
    logic [ADDR_W-1:0]       addr_next;
    logic                    wr_ok_next;
    cbse_pkg::tparam_t       t_next;
    cbse_pkg::point_t        point_next;

    cbse_pkg::op_t           op_reg    [cbse_pkg::ST_IN:cbse_pkg::ST_PP];
    logic [ADDR_W-1:0]       addr_reg  [cbse_pkg::ST_IN:cbse_pkg::ST_PP];
    logic                    wr_ok_reg [cbse_pkg::ST_IN:cbse_pkg::ST_PP];
    cbse_pkg::point_t        point_reg [cbse_pkg::ST_IN:cbse_pkg::ST_PP];
    cbse_pkg::tparam_t       t_reg;

    logic                    mem_wr_en;
    cbse_pkg::weight_t       weight_s6 [cbse_pkg::NUM_TAPS];
    cbse_pkg::point_t        point_s6  [cbse_pkg::NUM_TAPS];

    // a stage may load when it is empty or when its item moves on
    always_comb
    begin
        stage_en[cbse_pkg::NUM_STAGES] = !valid_reg[cbse_pkg::NUM_STAGES] || result_ready;
        for (int k = cbse_pkg::NUM_STAGES - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign item_ready   = stage_en[cbse_pkg::ST_IN];
    assign result_valid = valid_reg[cbse_pkg::NUM_STAGES];

    always_comb
    begin
        idx_ext = (SEL_W+1)'(point_index);
        seg_mod = idx_ext;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (seg_mod >= NP_SEL)
            begin
                seg_mod = seg_mod - NP_SEL;
            end
        end
        op_next    = cbse_pkg::op_t'(operation);
        wr_ok_next = (idx_ext < NP_SEL);
        addr_next  = (op_next == cbse_pkg::OP_EVAL) ? seg_mod[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];
        t_next     = (param_t > cbse_pkg::T_ONE) ? cbse_pkg::T_ONE : param_t;
        point_next = '{x: coord_x, y: coord_y};
    end

    // loads retire at the table stage; only evaluates travel further
    always_comb
    begin
        valid_next[cbse_pkg::ST_IN] = item_valid;
        for (int k = cbse_pkg::ST_IN + 1; k <= cbse_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
        valid_next[cbse_pkg::ST_MEM] = valid_reg[cbse_pkg::ST_PP]
                                    && (op_reg[cbse_pkg::ST_PP] == cbse_pkg::OP_EVAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= cbse_pkg::NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[cbse_pkg::ST_IN])
        begin
            op_reg[cbse_pkg::ST_IN]    <= op_next;
            addr_reg[cbse_pkg::ST_IN]  <= addr_next;
            wr_ok_reg[cbse_pkg::ST_IN] <= wr_ok_next;
            point_reg[cbse_pkg::ST_IN] <= point_next;
            t_reg                      <= t_next;
        end
        for (int k = cbse_pkg::ST_IN + 1; k <= cbse_pkg::ST_PP; k++)
        begin
            if (stage_en[k])
            begin
                op_reg[k]    <= op_reg[k-1];
                addr_reg[k]  <= addr_reg[k-1];
                wr_ok_reg[k] <= wr_ok_reg[k-1];
                point_reg[k] <= point_reg[k-1];
            end
        end
    end

    assign mem_wr_en = valid_reg[cbse_pkg::ST_PP]
                    && (op_reg[cbse_pkg::ST_PP] == cbse_pkg::OP_LOAD)
                    && wr_ok_reg[cbse_pkg::ST_PP];

    cbse_weight_gen u_weight_gen (
        .clk      (clk),
        .stage_en (stage_en),
        .t_in     (t_reg),
        .weight   (weight_s6)
    );

    cbse_point_store #(
        .NUM_POINTS (NUM_POINTS),
        .ADDR_W     (ADDR_W)
    ) u_point_store (
        .clk      (clk),
        .stage_en (stage_en),
        .wr_en    (mem_wr_en),
        .wr_addr  (addr_reg[cbse_pkg::ST_PP]),
        .wr_point (point_reg[cbse_pkg::ST_PP]),
        .rd_base  (addr_reg[cbse_pkg::ST_PP]),
        .rd_point (point_s6)
    );

    cbse_blend u_blend (
        .clk      (clk),
        .stage_en (stage_en),
        .weight   (weight_s6),
        .point    (point_s6),
        .curve_x  (curve_x),
        .curve_y  (curve_y)
    );

`ifndef SYNTHESIS
    // the four rounded basis weights always sum to one within rounding
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[cbse_pkg::ST_MEM] |->
            ((34'(weight_s6[0]) + 34'(weight_s6[1]) + 34'(weight_s6[2]) + 34'(weight_s6[3]))
                >= 34'h0_FFFF_FFFE)
            && ((34'(weight_s6[0]) + 34'(weight_s6[1]) + 34'(weight_s6[2]) + 34'(weight_s6[3]))
                <= 34'h1_0000_0002))
        else $error("basis weights do not sum to one");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[cbse_pkg::ST_PP]
            && ((op_reg[cbse_pkg::ST_PP] == cbse_pkg::OP_EVAL) || wr_ok_reg[cbse_pkg::ST_PP])
            |-> ({1'b0, addr_reg[cbse_pkg::ST_PP]} < (ADDR_W+1)'(NUM_POINTS)))
        else $error("table address outside the ring");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[cbse_pkg::ST_SUM] && !stage_en[cbse_pkg::ST_SUM]
            |=> valid_reg[cbse_pkg::ST_SUM])
        else $error("stalled item dropped from the adder stage");
`endif

endmodule

// ===== verif/closed_cubic_bspline_evaluator_unit_checker.sv =====
module closed_cubic_bspline_evaluator_unit_checker
    import cbse_pkg::*;
#(
    parameter int NUM_POINTS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic                operation,
    input  logic [IDX_W-1:0]    point_index,
    input  coord_t              coord_x,
    input  coord_t              coord_y,
    input  tparam_t             param_t,
    input  logic                result_valid,
    input  logic                result_ready,
    input  coord_t              curve_x,
    input  coord_t              curve_y,
    output int                  mismatches,
    output int                  outstanding,
    output int                  loads_seen,
    output int                  evals_seen,
    output int                  points_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    coord_t ring_x [NUM_POINTS];
    coord_t ring_y [NUM_POINTS];
    point_t pending_curve [$];

    int err_n;
    int load_n;
    int eval_n;
    int got_n;

    // Blends four neighbors on the ring with the uniform cubic basis, weights rounded to Q32.
    function automatic point_t curve_point(input logic [IDX_W-1:0] seg, input tparam_t t_in);
        bit [63:0]      t, t2, t3, u;
        bit [63:0]      raw [NUM_TAPS];
        longint signed  sx;
        longint signed  sy;
        longint signed  m;
        int unsigned    base;
        int unsigned    slot;
        point_t         p;
        t = (t_in > T_ONE) ? 64'(T_ONE) : 64'(t_in);
        t2 = t * t;
        t3 = t2 * t;
        u = 64'd65536 - t;
        raw[0] = u * u * u;
        raw[1] = (64'd4 << 48) + 64'd3 * t3 - ((64'd6 * t2) << 16);
        raw[2] = (64'd1 << 48) + ((64'd3 * t) << 32) + ((64'd3 * t2) << 16) - 64'd3 * t3;
        raw[3] = t3;
        base = int'(seg) % NUM_POINTS;
        sx = 0;
        sy = 0;
        for (int j = 0; j < NUM_TAPS; j++)
        begin
            m = longint'((raw[j] + (64'd3 << 16)) / (64'd6 << 16));
            slot = (base + j) % NUM_POINTS;
            sx += m * longint'(ring_x[slot]);
            sy += m * longint'(ring_y[slot]);
        end
        // round half up, then clamp to the coordinate range
        sx = (sx + 64'sd2147483648) >>> 32;
        sy = (sy + 64'sd2147483648) >>> 32;
        if (sx > 64'sd8388607)
            sx = 64'sd8388607;
        if (sx < -64'sd8388608)
            sx = -64'sd8388608;
        if (sy > 64'sd8388607)
            sy = 64'sd8388607;
        if (sy < -64'sd8388608)
            sy = -64'sd8388608;
        p.x = sx[COORD_W-1:0];
        p.y = sy[COORD_W-1:0];
        return p;
    endfunction

    always @(posedge clk)
    begin
        point_t want;
        if (!rst_n)
        begin
            pending_curve.delete();
            err_n = 0;
            load_n = 0;
            eval_n = 0;
            got_n = 0;
        end
        else
        begin
            // results leave before new transactions enter: latency keeps them distinct
            if (result_valid && result_ready)
            begin
                got_n++;
                if (pending_curve.size() == 0)
                begin
                    $error("unexpected curve point x=%0d y=%0d", curve_x, curve_y);
                    err_n++;
                end
                else
                begin
                    want = pending_curve.pop_front();
                    if (curve_x !== want.x)
                    begin
                        $error("curve_x expected %0d actual %0d", want.x, curve_x);
                        err_n++;
                    end
                    if (curve_y !== want.y)
                    begin
                        $error("curve_y expected %0d actual %0d", want.y, curve_y);
                        err_n++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                if (operation == OP_EVAL)
                begin
                    eval_n++;
                    pending_curve.push_back(curve_point(point_index, param_t));
                end
                else
                begin
                    load_n++;
                    if (point_index < NUM_POINTS)
                    begin
                        ring_x[point_index] = coord_x;
                        ring_y[point_index] = coord_y;
                    end
                end
            end
        end
        mismatches     <= err_n;
        outstanding    <= pending_curve.size();
        loads_seen     <= load_n;
        evals_seen     <= eval_n;
        points_checked <= got_n;
    end

endmodule

// ===== verif/closed_cubic_bspline_evaluator_unit_tb.sv =====
module closed_cubic_bspline_evaluator_unit_tb;
    import cbse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PTS     = 10;
    localparam int N_ITEMS   = 2000;
    localparam int HOLD_LEN  = 150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    logic               operation = OP_LOAD;
    logic [IDX_W-1:0]   point_index = '0;
    coord_t             coord_x = '0;
    coord_t             coord_y = '0;
    tparam_t            param_t = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    coord_t             curve_x;
    coord_t             curve_y;

    int mismatches;
    int outstanding;
    int loads_seen;
    int evals_seen;
    int points_checked;

    int  sent = 0;
    bit  send_quiet = 1'b0;
    bit  hold_active = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    closed_cubic_bspline_evaluator_unit #(
        .NUM_POINTS(N_PTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .operation   (operation),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .param_t     (param_t),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y)
    );

    closed_cubic_bspline_evaluator_unit_checker #(
        .NUM_POINTS(N_PTS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .param_t       (param_t),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .curve_x       (curve_x),
        .curve_y       (curve_y),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .loads_seen    (loads_seen),
        .evals_seen    (evals_seen),
        .points_checked(points_checked)
    );

    function automatic int idle_cycles(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic coord_t any_coord();
        case ($urandom_range(0, 7))
            0: return coord_t'(24'h7F_FFFF);
            1: return coord_t'(24'h80_0000);
            2: return coord_t'($signed($urandom_range(0, 511)) - 256);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic tparam_t any_t();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return T_ONE;
            2: return tparam_t'($urandom_range(65537, 131071));
            default: return tparam_t'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic offer(input op_t op, input int idx, input coord_t x, input coord_t y,
                         input tparam_t t);
        int gap;
        gap = hold_active ? 0 : idle_cycles(send_quiet);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        operation   <= op;
        point_index <= idx[IDX_W-1:0];
        coord_x     <= x;
        coord_y     <= y;
        param_t     <= t;
        do
            @(posedge clk);
        while (!item_ready);
        sent++;
        if (sent % 100 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // result side: random stalls, two long hold-offs while the sender keeps pushing
    initial
    begin : drain
        int gap;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (taken == 300 || taken == 1100)
            begin
                hold_active = 1'b1;
                gap = HOLD_LEN;
            end
            else
                gap = idle_cycles(quiet);
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            hold_active = 1'b0;
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            taken++;
            if (taken % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : stim
        int idx;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the ring: four points at the max-x/min-y corner, four at the opposite corner, then mixed
        for (int i = 0; i < 4; i++)
            offer(OP_LOAD, i, coord_t'(24'h7F_FFFF), coord_t'(24'h80_0000), T_ONE);
        for (int i = 4; i < 8; i++)
            offer(OP_LOAD, i, coord_t'(24'h80_0000), coord_t'(24'h7F_FFFF), '0);
        offer(OP_LOAD, 8, '0, '0, tparam_t'(17'h1_FFFF));
        offer(OP_LOAD, 9, coord_t'(24'h12_3456), coord_t'(24'hED_CBAA), '0);
        // slots past the ring are dropped
        offer(OP_LOAD, 15, '0, '0, '0);
        offer(OP_LOAD, 10, '0, '0, '0);

        offer(OP_EVAL, 0, '0, '0, '0);
        offer(OP_EVAL, 0, '0, '0, T_ONE);
        offer(OP_EVAL, 0, '0, '0, tparam_t'(17'h1_FFFF));   // clamps to one
        offer(OP_EVAL, 4, '0, '0, tparam_t'(32768));
        offer(OP_EVAL, 7, '0, '0, tparam_t'(1));            // wraps past the last slot
        offer(OP_EVAL, 9, '0, '0, tparam_t'(65535));
        offer(OP_EVAL, 15, '0, '0, tparam_t'(12345));       // segment taken mod ring size
        offer(OP_EVAL, 10, '0, '0, '0);
        offer(OP_EVAL, 3, '0, '0, tparam_t'(100000));
        offer(OP_LOAD, 8, coord_t'(-1), coord_t'(1), '0);
        offer(OP_EVAL, 8, '0, '0, tparam_t'(21845));

        while (sent < N_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                offer(OP_LOAD, $urandom_range(0, 15), any_coord(), any_coord(),
                      tparam_t'($urandom));
            else
            begin
                idx = $urandom_range(0, 15);
                offer(OP_EVAL, idx, coord_t'($urandom), coord_t'($urandom), any_t());
            end
        end
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (3 * NUM_STAGES) @(posedge clk);

        $display("Sent %0d transactions: %0d point loads and %0d curve evaluations,",
                 sent, loads_seen, evals_seen);
        $display("compared %0d curve points, two long output stalls included.",
                 points_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS closed_cubic_bspline_evaluator_unit");
        else
            $display("FAIL closed_cubic_bspline_evaluator_unit");
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("FAIL closed_cubic_bspline_evaluator_unit");
        $finish;
    end

endmodule
